>>> rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_FIND   = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_DONE
	} state_t;

	// Request handed from the top level to the engine.
	typedef struct packed {
		cmd_t              command;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} req_t;

	// Result handed back from the engine.
	typedef struct packed {
		logic              found;
		logic [DATA_W-1:0] read_value;
	} res_t;

endpackage

>>> rtl/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+---------------------------
//  in       | input     | in_valid / in_ready        | command, key, value
//  out      | output    | out_valid / out_ready      | found, read_value
//  cfg      | input     | cfg_write_en (no wait)     | cfg_write_data -> capacity
//
// A transfer runs as two scans: a lookup scan reads every entry of the memory
// once, then an update scan rewrites ranks, values and valid bits. A find
// that misses skips the update scan. With the single memory read port, each
// scan reads the entries one after another.
// Reset clears the valid bits and the output valid flag, and sets capacity to 16.
// A result waits in the output register; the next transfer is accepted meanwhile.
module lru_key_value_cache_unit import lkvc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     found,
	output logic signed [DATA_W-1:0] read_value,
	input  logic                     cfg_write_en,
	input  logic [CAP_W-1:0]         cfg_write_data
);

	logic [CAP_W-1:0] capacity_q;
	logic out_valid_q;
	logic found_q;
	logic [DATA_W-1:0] read_value_q;

	req_t req;
	res_t res;
	logic eng_idle;
	logic res_valid, res_ready;

	// Capacity register; values above ENTRIES are clamped inside the engine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_write_en) begin
			capacity_q <= cfg_write_data;
		end
	end

	assign req.command = cmd_t'(command);
	assign req.key     = key;
	assign req.value   = value;

	// A new transfer starts only while the engine sits idle
	assign in_ready = eng_idle;

	lkvc_engine #(.ENTRIES(ENTRIES)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req       (req),
		.idle      (eng_idle),
		.cap       (capacity_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register: frees the engine as soon as the result is parked here
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			found_q      <= res.found;
			read_value_q <= res.read_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = read_value_q;

endmodule

>>> rtl/lkvc_ram.sv
// Simple dual-port entry memory, one write and one registered read per cycle.
module lkvc_ram import lkvc_pkg::*; #(
	parameter int DEPTH = ENTRIES_DEF,
	parameter int WIDTH = 2 * DATA_W + 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/lkvc_engine.sv
// Lookup and rank-update sequencer: a lookup scan and, unless a find misses, an update scan over the entry memory.
module lkvc_engine import lkvc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  req_t             req,
	output logic             idle,
	input  logic [CAP_W-1:0] cap,
	output logic             res_valid,
	input  logic             res_ready,
	output res_t             res
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int RW = IW;
	localparam int CMPW = (RW + 1 > CAP_W) ? RW + 1 : CAP_W;
	localparam int MW = 2 * DATA_W + RW;
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
	localparam logic [CMPW-1:0] ENT_C = CMPW'(ENTRIES);

	state_t state_q, state_d;
	req_t req_q;

	logic [IW-1:0] addr_q;
	logic iss_q;
	logic rd_vld_s1;
	logic [IW-1:0] rd_idx_s1;
	logic hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [RW-1:0] hit_rank_q;
	logic [DATA_W-1:0] hit_val_q;
	logic placed_q;
	logic [ENTRIES-1:0] valid_q;

	logic [MW-1:0] rdata;
	logic [MW-1:0] wdata;
	logic we;

	logic [DATA_W-1:0] rd_key, rd_val;
	logic [RW-1:0] rd_rank;
	logic vld_now, match, last_data, go_upd;
	logic [CMPW-1:0] cap_ext, cap_eff;
	logic is_s, older;
	logic [CMPW-1:0] new_rank;
	logic keep, place;
	logic [DATA_W-1:0] wr_key, wr_val;

	lkvc_ram #(.DEPTH(ENTRIES), .WIDTH(MW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (rd_idx_s1),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign rd_key  = rdata[MW-1 -: DATA_W];
	assign rd_val  = rdata[RW +: DATA_W];
	assign rd_rank = rdata[RW-1:0];

	assign vld_now   = valid_q[rd_idx_s1];
	assign match     = rd_vld_s1 && vld_now && (rd_key == req_q.key);
	assign last_data = rd_vld_s1 && (rd_idx_s1 == LAST);
	assign go_upd    = (req_q.command == CMD_INSERT) || hit_q || match;

	assign cap_ext = CMPW'(cap);
	assign cap_eff = (cap_ext > ENT_C) ? ENT_C : cap_ext;

	// Per-entry rank update and eviction for the second scan
	always_comb begin
		is_s  = hit_q && (rd_idx_s1 == hit_idx_q);
		older = vld_now && (rd_rank < hit_rank_q);
		place = 1'b0;
		if (hit_q) begin
			if (is_s) begin
				new_rank = '0;
			end else if (older) begin
				new_rank = CMPW'(rd_rank) + CMPW'(1);
			end else begin
				new_rank = CMPW'(rd_rank);
			end
		end else begin
			new_rank = CMPW'(rd_rank) + CMPW'(1);
		end
		if (req_q.command == CMD_FIND) begin
			keep = vld_now;
		end else begin
			keep = vld_now && (new_rank < cap_eff);
		end
		wr_key = rd_key;
		wr_val = rd_val;
		if (req_q.command == CMD_INSERT) begin
			if (hit_q && is_s) begin
				wr_val = req_q.value;
			end
			if (!hit_q && !keep && !placed_q && (cap_eff != '0)) begin
				place    = 1'b1;
				wr_key   = req_q.key;
				wr_val   = req_q.value;
				new_rank = '0;
			end
		end
		we    = (state_q == ST_UPD) && rd_vld_s1;
		wdata = {wr_key, wr_val, new_rank[RW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idle      = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last_data) begin
					state_d = go_upd ? ST_UPD : ST_DONE;
				end
			end
			ST_UPD: begin
				if (last_data) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res.found      = hit_q;
	assign res.read_value = (req_q.command == CMD_FIND && hit_q) ? hit_val_q : '0;

	// Scan control and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q     <= 1'b0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			placed_q  <= 1'b0;
			valid_q   <= '0;
		end else begin
			rd_vld_s1 <= iss_q;
			if (iss_q) begin
				if (addr_q == LAST) begin
					iss_q <= 1'b0;
				end else begin
					addr_q <= addr_q + IW'(1);
				end
			end
			if (state_q == ST_IDLE && req_valid) begin
				iss_q    <= 1'b1;
				addr_q   <= '0;
				hit_q    <= 1'b0;
				placed_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (match) begin
					hit_q <= 1'b1;
				end
				if (last_data && go_upd) begin
					iss_q  <= 1'b1;
					addr_q <= '0;
				end
			end
			if (we) begin
				valid_q[rd_idx_s1] <= keep || place;
				if (place) begin
					placed_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
		if (state_q == ST_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == ST_SCAN && match) begin
			hit_idx_q  <= rd_idx_s1;
			hit_rank_q <= rd_rank;
			hit_val_q  <= rd_val;
		end
	end

endmodule

>>> sim/lru_key_value_cache_unit_tb.sv
// Self-checking testbench for the LRU key-value cache top level.
`timescale 1ns / 100ps

module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;

	localparam int ENTRIES      = ENTRIES_DEF;
	// Drain a bit longer than one transfer takes.
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 8;
	localparam int KEY_POOL_SZ  = 20;
	localparam int PHASE_ITEMS  = 43;
	// The long receiver hold-off starts once this many results have been taken.
	localparam int SQUEEZE_AT   = 120;
	localparam int SQUEEZE_LEN  = 300;

	// One row of the directed table. When typed is set, res holds the
	// hand-written expectation; otherwise the predictor supplies it.
	typedef struct {
		cmd_t              cmd;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] val;
		bit                typed;
		res_t              res;
	} stim_row_t;

	// ---------------------------------------------------------------------
	// DUT ports
	// ---------------------------------------------------------------------
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     command = 1'b0;
	logic signed [DATA_W-1:0] key = '0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic                     found;
	logic signed [DATA_W-1:0] read_value;
	logic                     cfg_write_en = 1'b0;
	logic [CAP_W-1:0]         cfg_write_data = '0;

	lru_key_value_cache_unit #(
		.ENTRIES (ENTRIES)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.key            (key),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.found          (found),
		.read_value     (read_value),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Shadow copy of the cache, used to predict each reply
	// ---------------------------------------------------------------------
	logic [DATA_W-1:0] slot_key   [ENTRIES];
	logic [DATA_W-1:0] slot_value [ENTRIES];
	logic              slot_live  [ENTRIES];
	logic [3:0]        slot_rank  [ENTRIES];   // 0 = most recently used
	logic [CAP_W-1:0]  live_count;
	logic [CAP_W-1:0]  capacity_model;

	// Replies predicted for accepted requests, oldest first.
	res_t lookup_replies [$];
	int   mismatch_count = 0;

	// Move slot s to the front; everything that was more recent ages by one.
	function automatic void refresh_slot(int s);
		logic [3:0] r;
		r = slot_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && slot_rank[i] < r)
				slot_rank[i]++;
		slot_rank[s] = '0;
	endfunction

	// Evict the live slot with the highest rank (first one on a tie).
	function automatic void drop_oldest();
		int pick;
		pick = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i] && (pick < 0 || slot_rank[i] > slot_rank[pick]))
				pick = i;
		if (pick >= 0) begin
			slot_live[pick] = 1'b0;
			slot_rank[pick] = '0;
			if (live_count > 0)
				live_count--;
		end
	endfunction

	// Apply one request to the shadow cache and return the reply it yields.
	function automatic res_t lru_access(cmd_t c, logic [DATA_W-1:0] k,
			logic [DATA_W-1:0] v);
		res_t             r;
		int               hit;
		bit               placed;
		logic [CAP_W-1:0] cap;
		// capacity above the table size behaves as the table size
		cap = (capacity_model > ENTRIES) ? CAP_W'(ENTRIES) : capacity_model;
		hit = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (hit < 0 && slot_live[i] && slot_key[i] == k)
				hit = i;
		r.found = (hit >= 0);
		r.read_value = '0;

		// find: hit returns the value and refreshes; a miss changes nothing
		if (c == CMD_FIND) begin
			if (hit >= 0) begin
				r.read_value = slot_value[hit];
				refresh_slot(hit);
			end
			return r;
		end

		// insert of a present key: overwrite, refresh, then trim to capacity
		if (hit >= 0) begin
			slot_value[hit] = v;
			refresh_slot(hit);
			while (live_count > cap)
				drop_oldest();
			return r;
		end

		// zero capacity: the cache ends up empty and the key is not kept
		if (cap == 0) begin
			while (live_count > 0)
				drop_oldest();
			return r;
		end

		// new key: make room first, age everyone, then take the first free slot
		while (live_count >= cap)
			drop_oldest();
		for (int i = 0; i < ENTRIES; i++)
			if (slot_live[i])
				slot_rank[i]++;
		placed = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (!placed && !slot_live[i]) begin
				slot_live[i]  = 1'b1;
				slot_key[i]   = k;
				slot_value[i] = v;
				slot_rank[i]  = '0;
				live_count++;
				placed = 1'b1;
			end
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Request side
	// ---------------------------------------------------------------------
	bit tx_steady = 1'b0;   // when set, requests go back to back

	// Offer one request, hold it until the transfer, then idle at random.
	// Called at a rising edge; returns at a rising edge.
	task automatic offer(input cmd_t c, input logic [DATA_W-1:0] k,
			input logic [DATA_W-1:0] v, input bit typed, input res_t typed_res);
		res_t pred;
		int   gap;
		int   p;
		in_valid <= 1'b1;
		command  <= c;
		key      <= k;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// transfer happened at this edge
		pred = lru_access(c, k, v);
		lookup_replies.push_back(typed ? typed_res : pred);
		p = $urandom_range(0, 99);
		if (tx_steady || p < 75)
			gap = 0;
		else if (p < 97)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(15, 50);
		// valid only drops when a gap follows, so no low/high pair in one step
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Directed table entry.
	stim_row_t directed_rows [$];

	function automatic void add_row(cmd_t c, logic [DATA_W-1:0] k,
			logic [DATA_W-1:0] v, bit typed, logic f, logic [DATA_W-1:0] rv);
		stim_row_t row;
		row.cmd = c;
		row.key = k;
		row.val = v;
		row.typed = typed;
		row.res.found = f;
		row.res.read_value = rv;
		directed_rows.push_back(row);
	endfunction

	// Capacity per random phase: above the table, tiny, zero, back to the reset value, lowered
	// while full, above the table again, zero from a full table, then 8, 1 and 5.
	logic [CAP_W-1:0] phase_caps [$] = '{5'd31, 5'd2, 5'd0, 5'd16, 5'd3,
		5'd17, 5'd0, 5'd8, 5'd1, 5'd5};

	logic [DATA_W-1:0] key_pool [KEY_POOL_SZ];

	initial begin
		stim_row_t         row;
		res_t              nores;
		cmd_t              c;
		logic [DATA_W-1:0] k;
		logic [CAP_W-1:0]  eff;
		int                span;

		nores = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_key[i]   = '0;
			slot_value[i] = '0;
			slot_live[i]  = 1'b0;
			slot_rank[i]  = '0;
		end
		live_count     = '0;
		capacity_model = CAP_RESET;

		// keys that phases draw from, so hits, updates and evictions are common
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < KEY_POOL_SZ; i++)
			key_pool[i] = $urandom;

		// directed part: empty cache, extreme keys and values, update, miss
		add_row(CMD_FIND,   32'h0000_0000, 32'h0000_0000, 1, 1'b0, 32'h0000_0000);
		add_row(CMD_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1'b0, 32'h0000_0000);
		add_row(CMD_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1'b0, 32'h0000_0000);
		add_row(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1, 1'b0, 32'h0000_0000);
		add_row(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000);
		add_row(CMD_FIND,   32'h8000_0000, 32'h0000_0000, 1, 1'b1, 32'h7FFF_FFFF);
		add_row(CMD_FIND,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1'b1, 32'h8000_0000);
		add_row(CMD_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'hFFFF_FFFF);
		// hit on a stored zero: found with a zero value
		add_row(CMD_FIND,   32'h0000_0000, 32'h1234_5678, 1, 1'b1, 32'h0000_0000);
		// insert of a present key replaces the value, reply has zero value
		add_row(CMD_INSERT, 32'h7FFF_FFFF, 32'h1234_5678, 1, 1'b1, 32'h0000_0000);
		add_row(CMD_FIND,   32'h7FFF_FFFF, 32'h0000_0000, 1, 1'b1, 32'h1234_5678);
		// miss: value field is ignored
		add_row(CMD_FIND,   32'h0000_0001, 32'hFFFF_FFFF, 1, 1'b0, 32'h0000_0000);
		// fill the table, then one more new key pushes out the oldest entry
		for (int i = 0; i < 13; i++)
			add_row(CMD_INSERT, 32'h0000_0100 + i, $urandom, 0, 1'b0, '0);
		add_row(CMD_FIND, 32'h8000_0000, 32'h0, 0, 1'b0, '0);

		// reset held low from the start, released on an edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_steady = ($urandom_range(0, 2) == 0);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			offer(row.cmd, row.key, row.val, row.typed, row.res);
		end
		in_valid <= 1'b0;

		foreach (phase_caps[ph]) begin
			// capacity changes only with the pipe empty and the engine quiet
			while (lookup_replies.size() != 0)
				@(posedge clk);
			repeat (DRAIN_CYCLES) @(posedge clk);
			cfg_write_en   <= 1'b1;
			cfg_write_data <= phase_caps[ph];
			@(posedge clk);
			cfg_write_en   <= 1'b0;
			capacity_model = phase_caps[ph];

			// draw keys from a span a little wider than the capacity
			eff  = (phase_caps[ph] > ENTRIES) ? CAP_W'(ENTRIES) : phase_caps[ph];
			span = eff + 4;
			if (span > KEY_POOL_SZ)
				span = KEY_POOL_SZ;
			tx_steady = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				c = cmd_t'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, span - 1)];
				else
					k = $urandom;
				offer(c, k, $urandom, 0, nores);
			end
			in_valid <= 1'b0;
		end

		// wait for every pending reply, then for anything stray
		while (lookup_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && lookup_replies.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Reply side: check every transfer and throttle out_ready
	// ---------------------------------------------------------------------
	int   rx_count     = 0;
	int   rx_hold_left = 0;
	int   rx_cycle     = 0;
	int   rx_roll;
	bit   rx_steady    = 1'b0;
	bit   squeeze_done = 1'b0;
	res_t rx_want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			rx_count++;
			if (lookup_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: reply with nothing pending: found=%0b value=%h",
						$realtime, found, read_value);
			end else begin
				rx_want = lookup_replies.pop_front();
				if (found !== rx_want.found || read_value !== rx_want.read_value) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: reply mismatch: want found=%0b value=%h, got found=%0b value=%h",
							$realtime, rx_want.found, rx_want.read_value, found, read_value);
				end
			end
		end

		// pick out_ready for the next cycle
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (!squeeze_done && rx_count >= SQUEEZE_AT) begin
			// long hold-off: the request side keeps offering and backs up
			squeeze_done = 1'b1;
			rx_hold_left = SQUEEZE_LEN - 1;
			out_ready <= 1'b0;
		end else if (rx_steady) begin
			out_ready <= 1'b1;
		end else begin
			rx_roll = $urandom_range(0, 99);
			if (rx_roll < 70) begin
				out_ready <= 1'b1;
			end else if (rx_roll < 97) begin
				rx_hold_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				rx_hold_left = $urandom_range(20, 80);
				out_ready <= 1'b0;
			end
		end

		// stretches of always-ready now and then
		rx_cycle++;
		if (rx_cycle % 97 == 0)
			rx_steady = ($urandom_range(0, 3) == 0);
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
